### sv/apc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_pkg
// Shared constants and types of the actuator pattern controller.
// ----------------------------------------------------------------------------
package apc_pkg;

  localparam int PHASE_PERIOD_DEF = 32;

  localparam int CNT_W   = 8;
  localparam int BYTE_W  = 8;
  localparam int LEVEL_W = 6;
  localparam int IDX_W   = 8;
  localparam int OUT_W   = 16;

  localparam logic [CNT_W-1:0] LED_BLINK_RST = 8'd5;
  localparam logic [CNT_W-1:0] VIB_PULSE_RST = 8'd5;

  localparam logic [IDX_W-1:0] REG_LED_BLINK_COUNT     = 8'd0;
  localparam logic [IDX_W-1:0] REG_VIBRATE_PULSE_COUNT = 8'd1;

  localparam logic [BYTE_W-1:0] CMD_REPORT      = 8'h30;
  localparam logic [BYTE_W-1:0] CMD_LED_ON      = 8'h31;
  localparam logic [BYTE_W-1:0] CMD_LED_OFF     = 8'h32;
  localparam logic [BYTE_W-1:0] CMD_LED_NOTIFY  = 8'h33;
  localparam logic [BYTE_W-1:0] CMD_HEATER_ON   = 8'h34;
  localparam logic [BYTE_W-1:0] CMD_HEATER_OFF  = 8'h35;
  localparam logic [BYTE_W-1:0] CMD_VIB_NOTIFY  = 8'h36;
  localparam logic [BYTE_W-1:0] CMD_BUZZER_ON   = 8'h37;
  localparam logic [BYTE_W-1:0] CMD_BUZZER_OFF  = 8'h38;
  localparam logic [BYTE_W-1:0] CMD_MASSAGE_1   = 8'h61;
  localparam logic [BYTE_W-1:0] CMD_MASSAGE_2   = 8'h62;
  localparam logic [BYTE_W-1:0] CMD_MASSAGE_3   = 8'h63;
  localparam logic [BYTE_W-1:0] CMD_MASSAGE_4   = 8'h64;
  localparam logic [BYTE_W-1:0] CMD_MASSAGE_5   = 8'h65;
  localparam logic [BYTE_W-1:0] CMD_MASSAGE_OFF = 8'h66;

  typedef struct packed {
    logic              report_request;
    logic [BYTE_W-1:0] echo_byte;
    logic              echo_valid;
    logic              heater_on;
    logic              massage_on;
    logic              vibrate_on;
    logic              buzzer_on;
    logic              led_on;
  } apc_result_t;

endpackage

### sv/apc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_core
// Mode state, phase counter and drive evaluation, one request per cycle.
// ----------------------------------------------------------------------------
module apc_core #(
  parameter int PHASE_PERIOD = apc_pkg::PHASE_PERIOD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_fire,
  input  logic                       in_op,
  input  logic [apc_pkg::BYTE_W-1:0] in_byte,
  input  logic                       cfg_fire,
  input  logic [apc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [apc_pkg::CNT_W-1:0]  cfg_data,
  output apc_pkg::apc_result_t       result
);
  import apc_pkg::*;

  localparam int PHASE_W = $clog2(PHASE_PERIOD);
  localparam int CMP_W   = 7;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               led_mode;
    logic               led_notify_active;
    logic               led_notify_high;
    logic [CNT_W-1:0]   led_blinks_left;
    logic               buzzer_mode;
    logic               vibrate_active;
    logic               vibrate_high;
    logic [CNT_W-1:0]   pulses_left;
    logic               massage_mode;
    logic [LEVEL_W-1:0] massage_level;
  } state_t;

  typedef struct packed {
    logic led;
    logic buzzer;
    logic vibrate;
    logic massage;
    logic heater;
  } drive_t;

  state_t           st, st_next;
  drive_t           drv, drv_next;
  logic [CNT_W-1:0] led_blink_count;
  logic [CNT_W-1:0] vibrate_pulse_count;
  logic             blink_hi;
  logic             vib_hi;

  always_comb begin
    st_next  = st;
    drv_next = drv;
    if (!in_op) begin
      if (st.phase == PHASE_W'(PHASE_PERIOD - 1)) begin
        st_next.phase = '0;
      end else begin
        st_next.phase = st.phase + PHASE_W'(1);
      end
    end else begin
      case (in_byte)
        CMD_LED_ON:  st_next.led_mode = 1'b1;
        CMD_LED_OFF: st_next.led_mode = 1'b0;
        CMD_LED_NOTIFY: begin
          st_next.led_notify_active = 1'b1;
          st_next.led_notify_high   = 1'b0;
          st_next.led_blinks_left   = led_blink_count;
        end
        CMD_MASSAGE_1: begin
          st_next.massage_mode  = 1'b1;
          st_next.massage_level = 6'd2;
        end
        CMD_MASSAGE_2: begin
          st_next.massage_mode  = 1'b1;
          st_next.massage_level = 6'd4;
        end
        CMD_MASSAGE_3: begin
          st_next.massage_mode  = 1'b1;
          st_next.massage_level = 6'd8;
        end
        CMD_MASSAGE_4: begin
          st_next.massage_mode  = 1'b1;
          st_next.massage_level = 6'd16;
        end
        CMD_MASSAGE_5: begin
          st_next.massage_mode  = 1'b1;
          st_next.massage_level = 6'd32;
        end
        CMD_MASSAGE_OFF: begin
          st_next.massage_mode  = 1'b0;
          st_next.massage_level = '0;
          drv_next.massage      = 1'b0;
        end
        CMD_VIB_NOTIFY: begin
          st_next.vibrate_active = 1'b1;
          st_next.vibrate_high   = 1'b0;
          st_next.pulses_left    = vibrate_pulse_count;
        end
        CMD_BUZZER_ON: st_next.buzzer_mode = 1'b1;
        CMD_BUZZER_OFF: begin
          st_next.buzzer_mode = 1'b0;
          drv_next.buzzer     = 1'b0;
        end
        CMD_HEATER_ON:  drv_next.heater = 1'b1;
        CMD_HEATER_OFF: drv_next.heater = 1'b0;
        default: ;
      endcase
    end

    blink_hi = st_next.phase[3];
    vib_hi   = st_next.phase[2];

    drv_next.led = st_next.led_mode;
    if (st_next.led_notify_active) begin
      if (blink_hi) begin
        st_next.led_notify_high = 1'b1;
        drv_next.led            = 1'b1;
      end else begin
        if (st_next.led_notify_high) begin
          st_next.led_notify_high = 1'b0;
          st_next.led_blinks_left = st_next.led_blinks_left - CNT_W'(1);
        end
        drv_next.led = 1'b0;
      end
      if (st_next.led_blinks_left == '0) begin
        st_next.led_notify_active = 1'b0;
        st_next.led_notify_high   = 1'b0;
      end
    end

    if (st_next.buzzer_mode) begin
      drv_next.buzzer = blink_hi;
    end

    if (st_next.vibrate_active) begin
      if (vib_hi) begin
        drv_next.vibrate     = 1'b1;
        st_next.vibrate_high = 1'b1;
      end else begin
        if (st_next.vibrate_high) begin
          st_next.vibrate_high = 1'b0;
          st_next.pulses_left  = st_next.pulses_left - CNT_W'(1);
        end
        drv_next.vibrate = 1'b0;
      end
      if (st_next.pulses_left == '0) begin
        st_next.vibrate_active = 1'b0;
      end
    end

    if (st_next.massage_mode) begin
      drv_next.massage = {{(CMP_W-PHASE_W){1'b0}}, st_next.phase}
                         < {1'b0, st_next.massage_level};
    end
  end

  always_comb begin
    result.led_on         = drv_next.led;
    result.buzzer_on      = drv_next.buzzer;
    result.vibrate_on     = drv_next.vibrate;
    result.massage_on     = drv_next.massage;
    result.heater_on      = drv_next.heater;
    result.echo_valid     = in_op;
    result.echo_byte      = in_op ? in_byte : '0;
    result.report_request = in_op && (in_byte == CMD_REPORT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '0;
      drv <= '0;
    end else if (in_fire) begin
      st  <= st_next;
      drv <= drv_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_blink_count     <= LED_BLINK_RST;
      vibrate_pulse_count <= VIB_PULSE_RST;
    end else if (cfg_fire) begin
      if (cfg_index == REG_LED_BLINK_COUNT) begin
        led_blink_count <= cfg_data;
      end else if (cfg_index == REG_VIBRATE_PULSE_COUNT) begin
        vibrate_pulse_count <= cfg_data;
      end
    end
  end

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    st.phase < PHASE_W'(PHASE_PERIOD - 1) || st.phase == PHASE_W'(PHASE_PERIOD - 1))
    else $error("phase out of range");

  a_notify_high: assert property (@(posedge clk) disable iff (rst)
    st.led_notify_high |-> st.led_notify_active)
    else $error("led notify high without active notification");

  a_buzzer_off: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_op && in_byte == CMD_BUZZER_OFF |=> !drv.buzzer && !st.buzzer_mode)
    else $error("buzzer not forced off");

  a_massage_off: assert property (@(posedge clk) disable iff (rst)
    in_fire && in_op && in_byte == CMD_MASSAGE_OFF |=> !drv.massage && st.massage_level == '0)
    else $error("massage not forced off");

endmodule

### sv/apc_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apc_out_buf
// Two-entry result buffer between the update logic and the output stream.
// ----------------------------------------------------------------------------
module apc_out_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  apc_pkg::apc_result_t push_data,
  output logic                 space,
  output logic                 out_valid,
  input  logic                 out_ready,
  output apc_pkg::apc_result_t out_data
);
  import apc_pkg::*;

  apc_result_t r0, r1;
  logic [1:0]  count;
  logic        pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 2'd0;
  assign space     = count != 2'd2;
  assign out_data  = r0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      r0 <= push_data;
    end else if (pop && count == 2'd2) begin
      r0 <= r1;
    end
    if (push && ((count == 2'd1 && !pop) || (count == 2'd2 && pop))) begin
      r1 <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 && !pop |=> count == 2'd2)
    else $error("result buffer lost an entry");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count invalid");

  a_hold_head: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(r0))
    else $error("stalled result changed");

endmodule

### sv/actuator_pattern_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// actuator_pattern_controller
// Tick and command driven LED, buzzer, vibration, massage and heater control.
// ----------------------------------------------------------------------------
// One request is accepted per clock cycle while the result buffer has room.
// Each request (a timer tick when tuser is 0, a command byte when tuser is 1)
// updates the phase or mode state; its result is registered into a
// two-entry result buffer that lets requests keep flowing while one result
// waits. s_axis_tready drops only when both entries are held. Count
// registers are written through the cfg channel, which is always ready.
module actuator_pattern_controller #(
  parameter int PHASE_PERIOD = apc_pkg::PHASE_PERIOD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,  // [7:0] rx_byte
  input  logic                       s_axis_tuser,  // [0] op
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [0] led_on, [1] buzzer_on, [2] vibrate_on, [3] massage_on, [4] heater_on,
  // [5] echo_valid, [13:6] echo_byte, [14] report_request, [15] zero
  output logic [apc_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [apc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [apc_pkg::CNT_W-1:0]  cfg_data
);
  import apc_pkg::*;

  apc_result_t result, out_data;
  logic        in_fire;
  logic        space;

  assign s_axis_tready = space;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  apc_core #(
    .PHASE_PERIOD(PHASE_PERIOD)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_op    (s_axis_tuser),
    .in_byte  (s_axis_tdata),
    .cfg_fire (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .result   (result)
  );

  apc_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (in_fire),
    .push_data(result),
    .space    (space),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (out_data)
  );

  assign m_axis_tdata = {1'b0, out_data.report_request, out_data.echo_byte,
                         out_data.echo_valid, out_data.heater_on, out_data.massage_on,
                         out_data.vibrate_on, out_data.buzzer_on, out_data.led_on};

endmodule
